/* sv/dpb_pkg.sv */
// Shared types, constants and configuration reset values for the depth pixel
// back-projection block. No dependencies.

package dpb_pkg;

    localparam int DEFAULT_STRIDE    = 3;
    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int QUEUE_DEPTH       = 4;

    localparam int DEPTH_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int COORD_W   = 32;
    localparam int CENTER_W  = 16;
    localparam int INV_W     = 24;
    localparam int DIM_W     = 13;
    localparam int ROW_W     = 12;
    localparam int POS_FRAC  = 4;
    localparam int OFF_W     = 16;
    localparam int FRAC_SHIFT = 28;
    localparam int PROD1_W   = OFF_W + DEPTH_W;
    localparam int PROD2_W   = PROD1_W + INV_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CENTER_W-1:0] RST_CENTER_X  = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y  = 16'd3840;
    localparam logic [INV_W-1:0]    RST_INV_FX    = 24'd8389;
    localparam logic [INV_W-1:0]    RST_INV_FY    = 24'd8389;
    localparam logic [DIM_W-1:0]    RST_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]    RST_HEIGHT    = 13'd480;
    localparam logic [DEPTH_W-1:0]  RST_DEPTH_MIN = 16'd41;
    localparam logic [DEPTH_W-1:0]  RST_DEPTH_MAX = 16'd36864;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_INV_FX    = 3'd2,
        CFG_INV_FY    = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5,
        CFG_DEPTH_MIN = 3'd6,
        CFG_DEPTH_MAX = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic [DEPTH_W-1:0]  depth_min;
        logic [DEPTH_W-1:0]  depth_max;
    } t_cfg;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] red_in;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic [COLOR_W-1:0]        blue_out;
        logic [COLOR_W-1:0]        green_out;
        logic [COLOR_W-1:0]        red_out;
    } t_point;

    typedef struct packed {
        logic               neg_x;
        logic [OFF_W-1:0]   off_x;
        logic               neg_y;
        logic [OFF_W-1:0]   off_y;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_job;

endpackage

/* sv/dpb_front.sv */
// Front end: raster position counters, stride and depth window test, signed
// pixel offsets from the principal point. Depends on dpb_pkg.

module dpb_front #(
    parameter int STRIDE    = dpb_pkg::DEFAULT_STRIDE,
    parameter int MAX_WIDTH = dpb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dpb_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  dpb_pkg::t_pixel i_pixel,
    output logic          o_stall,
    input  logic          i_queue_full,
    output logic          o_push,
    output dpb_pkg::t_job o_job
);
    import dpb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PH_W  = (STRIDE > 1) ? $clog2(STRIDE) : 1;
    localparam int P16_W = OFF_W + 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(STRIDE - 1);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PH_W-1:0]  r_col_ph, n_col_ph;
    logic [PH_W-1:0]  r_row_ph, n_row_ph;

    logic             accept;
    logic             hit;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [P16_W-1:0] px16, py16, cx, cy;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    always_comb begin
        w_eff = (i_cfg.image_width == '0 || i_cfg.image_width > DIM_W'(MAX_WIDTH))
              ? DIM_W'(MAX_WIDTH) : i_cfg.image_width;
        h_eff = (i_cfg.image_height == '0 || i_cfg.image_height > DIM_W'(MAX_HEIGHT))
              ? DIM_W'(MAX_HEIGHT) : i_cfg.image_height;

        n_col    = r_col;
        n_row    = r_row;
        n_col_ph = r_col_ph;
        n_row_ph = r_row_ph;
        if (DIM_W'(r_col) + DIM_W'(1) >= w_eff) begin
            n_col    = '0;
            n_col_ph = '0;
            if (DIM_W'(r_row) + DIM_W'(1) >= h_eff) begin
                n_row    = '0;
                n_row_ph = '0;
            end else begin
                n_row    = r_row + ROW_W'(1);
                n_row_ph = (r_row_ph == PH_LAST) ? '0 : r_row_ph + PH_W'(1);
            end
        end else begin
            n_col    = r_col + COL_W'(1);
            n_col_ph = (r_col_ph == PH_LAST) ? '0 : r_col_ph + PH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

    always_comb begin
        hit = (r_col_ph == '0) && (r_row_ph == '0)
           && (i_pixel.depth >= i_cfg.depth_min) && (i_pixel.depth <= i_cfg.depth_max);

        px16 = P16_W'({r_col, {POS_FRAC{1'b0}}});
        py16 = P16_W'({r_row, {POS_FRAC{1'b0}}});
        cx   = P16_W'(i_cfg.center_x);
        cy   = P16_W'(i_cfg.center_y);

        o_job.neg_x = px16 < cx;
        o_job.off_x = o_job.neg_x ? OFF_W'(cx - px16) : OFF_W'(px16 - cx);
        o_job.neg_y = py16 < cy;
        o_job.off_y = o_job.neg_y ? OFF_W'(cy - py16) : OFF_W'(py16 - cy);
        o_job.depth = i_pixel.depth;
        o_job.blue  = i_pixel.blue_in;
        o_job.green = i_pixel.green_in;
        o_job.red   = i_pixel.red_in;
    end

    assign o_push = accept && hit;

endmodule

/* sv/dpb_queue.sv */
// Short register queue of accepted points between front and back end.
// Depends on dpb_pkg.

module dpb_queue #(
    parameter int DEPTH = dpb_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpb_pkg::t_job i_job,
    input  logic          i_pop,
    output dpb_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import dpb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/dpb_back.sv */
// Back end: three-stage multiply pipeline (offset*depth, *reciprocal, round
// and saturate) ending in the output register. Depends on dpb_pkg.

module dpb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dpb_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  dpb_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_valid,
    output dpb_pkg::t_point o_point,
    input  logic           i_stall
);
    import dpb_pkg::*;

    localparam int RND_W = PROD2_W + 1;
    localparam int MAG_W = COORD_W + 1;
    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(33'h0_7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(33'h0_8000_0000);
    localparam logic [RND_W-1:0] HALF      = RND_W'(1) << (FRAC_SHIFT - 1);

    logic                en;

    logic                r_v1;
    logic                r_neg_x1, r_neg_y1;
    logic [PROD1_W-1:0]  r_p1x, r_p1y;
    logic [DEPTH_W-1:0]  r_z1;
    logic [COLOR_W-1:0]  r_b1, r_g1, r_r1;

    logic                r_v2;
    logic                r_neg_x2, r_neg_y2;
    logic [PROD2_W-1:0]  r_p2x, r_p2y;
    logic [DEPTH_W-1:0]  r_z2;
    logic [COLOR_W-1:0]  r_b2, r_g2, r_r2;

    logic                r_out_valid;
    t_point              r_point;

    function automatic logic [COORD_W-1:0] finish(input logic [PROD2_W-1:0] prod,
                                                  input logic neg);
        logic [RND_W-1:0] rnd;
        logic [MAG_W-1:0] mag;
        rnd = RND_W'(prod) + HALF;
        mag = MAG_W'(rnd >> FRAC_SHIFT);
        if (neg) begin
            if (mag > NEG_LIMIT) begin
                mag = NEG_LIMIT;
            end
            finish = COORD_W'(0) - mag[COORD_W-1:0];
        end else begin
            if (mag > POS_LIMIT) begin
                mag = POS_LIMIT;
            end
            finish = mag[COORD_W-1:0];
        end
    endfunction

    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_out_valid;
    assign o_point = r_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= !i_empty;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg_x1 <= i_job.neg_x;
            r_neg_y1 <= i_job.neg_y;
            r_p1x    <= PROD1_W'(i_job.off_x) * PROD1_W'(i_job.depth);
            r_p1y    <= PROD1_W'(i_job.off_y) * PROD1_W'(i_job.depth);
            r_z1     <= i_job.depth;
            r_b1     <= i_job.blue;
            r_g1     <= i_job.green;
            r_r1     <= i_job.red;

            r_neg_x2 <= r_neg_x1;
            r_neg_y2 <= r_neg_y1;
            r_p2x    <= PROD2_W'(r_p1x) * PROD2_W'(i_cfg.inv_focal_x);
            r_p2y    <= PROD2_W'(r_p1y) * PROD2_W'(i_cfg.inv_focal_y);
            r_z2     <= r_z1;
            r_b2     <= r_b1;
            r_g2     <= r_g1;
            r_r2     <= r_r1;

            r_point.point_x   <= finish(r_p2x, r_neg_x2);
            r_point.point_y   <= finish(r_p2y, r_neg_y2);
            r_point.point_z   <= r_z2;
            r_point.blue_out  <= r_b2;
            r_point.green_out <= r_g2;
            r_point.red_out   <= r_r2;
        end
    end

endmodule

/* sv/depth_pixel_backprojection.sv */
// Top level of the depth pixel back-projection block: configuration registers,
// front end, point queue and multiply back end. Depends on dpb_pkg and submodules.
//
// Turns a raster stream of depth and colour pixels into colored 3D points using
// the pinhole model: z = depth, x = (col - cx) * z / fx, y = (row - cy) * z / fy,
// with the focal divisions done as multiplies by Q0.24 reciprocal registers.
// One pixel is taken every clock while the four-entry point queue has room;
// o_stall rises only when that queue is full. Each kept pixel (row and column
// on the stride grid, depth inside the window) passes from input to o_valid
// through a queue write and three pipeline stages (offset times depth,
// times reciprocal, round and saturate), and points leave at one per clock
// when i_stall is low. Throughput is set by the position counters, which
// update on every accepted pixel, and the fully pipelined multipliers. Write
// the configuration only while no point is in flight.

module depth_pixel_backprojection #(
    parameter int STRIDE    = dpb_pkg::DEFAULT_STRIDE,
    parameter int MAX_WIDTH = dpb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    input  dpb_pkg::t_pixel                     i_pixel,
    output logic                                o_stall,
    output logic                                o_valid,
    output dpb_pkg::t_point                     o_point,
    input  logic                                i_stall
);
    import dpb_pkg::*;

    t_cfg r_cfg;
    t_job front_job, queue_job;
    logic push, pop, q_empty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x     <= RST_CENTER_X;
            r_cfg.center_y     <= RST_CENTER_Y;
            r_cfg.inv_focal_x  <= RST_INV_FX;
            r_cfg.inv_focal_y  <= RST_INV_FY;
            r_cfg.image_width  <= RST_WIDTH;
            r_cfg.image_height <= RST_HEIGHT;
            r_cfg.depth_min    <= RST_DEPTH_MIN;
            r_cfg.depth_max    <= RST_DEPTH_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X:  r_cfg.center_x     <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:  r_cfg.center_y     <= i_cfg_data[CENTER_W-1:0];
                CFG_INV_FX:    r_cfg.inv_focal_x  <= i_cfg_data[INV_W-1:0];
                CFG_INV_FY:    r_cfg.inv_focal_y  <= i_cfg_data[INV_W-1:0];
                CFG_WIDTH:     r_cfg.image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    r_cfg.image_height <= i_cfg_data[DIM_W-1:0];
                CFG_DEPTH_MIN: r_cfg.depth_min    <= i_cfg_data[DEPTH_W-1:0];
                CFG_DEPTH_MAX: r_cfg.depth_max    <= i_cfg_data[DEPTH_W-1:0];
                default:       r_cfg              <= r_cfg;
            endcase
        end
    end

    dpb_front #(
        .STRIDE    (STRIDE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .i_pixel      (i_pixel),
        .o_stall      (o_stall),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    dpb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_job   (queue_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_point (o_point),
        .i_stall (i_stall)
    );

endmodule

/* sv/dpb_checker.sv */
// Port-level checks for depth_pixel_backprojection and the bind that attaches
// them. Depends on dpb_pkg.

module dpb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_stall,
    input logic            o_stall,
    input logic            o_valid,
    input dpb_pkg::t_point o_point
);
    import dpb_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point))
        else $error("stalled point changed or dropped");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("point valid right after reset");

    a_reset_queue: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point.point_z == '0 |-> o_point.point_x == '0 && o_point.point_y == '0)
        else $error("zero depth point off the optical center");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_stall (i_stall),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_point (o_point)
);
